### rtl/adx_trend_position_engine_unit_assert.svh
// assertion macros used by the checker file
`ifndef ADX_TREND_POSITION_ENGINE_UNIT_ASSERT_SVH
`define ADX_TREND_POSITION_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define ADXE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adxe check failed");

// next-cycle implication, held off during reset
`define ADXE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adxe check failed");

// next-cycle implication that also runs through reset
`define ADXE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("adxe check failed");

`endif

### rtl/adxe_pkg.sv
package adxe_pkg;

   localparam int PRICE_BITS    = 24;
   localparam int FRAC_BITS     = 16;
   localparam int ATR_BITS      = PRICE_BITS + FRAC_BITS;
   localparam int DI_BITS       = FRAC_BITS + 1;
   localparam int PCT_BITS      = 23;
   localparam int ALPHA_BITS    = 17;
   localparam int LIMIT_BITS    = 15;
   localparam int POS_BITS      = 16;
   localparam int CASH_BITS     = 48;
   localparam int ACT_BITS      = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 23;
   localparam int QUO_BITS      = PCT_BITS;
   localparam int CNT_BITS      = 5;
   localparam int MUL_A_BITS    = PRICE_BITS + 1;
   localparam int MUL_B_BITS    = ALPHA_BITS + 1;
   localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;

   localparam logic [ALPHA_BITS-1:0]    ALPHA_ONE       = 17'd65536;
   localparam logic [PCT_BITS-1:0]      THRESHOLD_RESET = 23'd1638400;
   localparam logic [ALPHA_BITS-1:0]    ALPHA_RESET     = 17'd8738;
   localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET     = 15'd10;

   localparam logic [CSR_IDX_BITS-1:0]  CSR_ADX_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0]  CSR_SMOOTHING_ALPHA = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0]  CSR_POSITION_LIMIT  = 2'd2;

   localparam logic [ACT_BITS-1:0] ACT_HOLD = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_BUY  = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_SELL = 2'd2;

   localparam logic [CNT_BITS-1:0] DI_STEPS = CNT_BITS'(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] DX_STEPS = CNT_BITS'(QUO_BITS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_SM_HI,
      S_SM_LO,
      S_DIVP_INIT,
      S_DIVP_RUN,
      S_DIVM_INIT,
      S_DIVM_RUN,
      S_DX_INIT,
      S_DX_RUN,
      S_TRADE,
      S_PNL,
      S_PNL_SUM
   } state_type;

   typedef enum logic [1:0] {
      SM_ATR,
      SM_DIP,
      SM_DIM,
      SM_ADX
   } sm_sel_type;

   typedef struct packed {
      logic                start;
      logic [CNT_BITS-1:0] steps;
      logic [ATR_BITS-1:0] rem_init;
      logic [QUO_BITS-1:0] shift_init;
      logic [ATR_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/adx_trend_position_engine_unit.sv
// channel | direction | handshake        | payload
// req     | in        | req_valid/stall  | bar_high, bar_low, prior_close, bar_close
// rsp     | out       | rsp_valid/stall  | action, position, cashflow, marked_pnl, adx_value
// csr     | in        | csr_write_enable | csr_index, csr_write_data
//
// the first bar after reset is taken and gives no result
// a later bar runs two 17-step DI divisions and one 23-step DX division (each skipped
// when its result is known) and, once seeded, a high and a low multiplier step per series
// reset is synchronous and clears all series, position and cash
// a finished result waits in the output register; the next bar is taken meanwhile
// and only stalls at its final step if the result is still held
module adx_trend_position_engine_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [adxe_pkg::PRICE_BITS-1:0]        req_bar_high,
   input  logic [adxe_pkg::PRICE_BITS-1:0]        req_bar_low,
   input  logic [adxe_pkg::PRICE_BITS-1:0]        req_prior_close,
   input  logic [adxe_pkg::PRICE_BITS-1:0]        req_bar_close,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [adxe_pkg::ACT_BITS-1:0]          rsp_action,
   output logic signed [adxe_pkg::POS_BITS-1:0]   rsp_position,
   output logic signed [adxe_pkg::CASH_BITS-1:0]  rsp_cashflow,
   output logic signed [adxe_pkg::CASH_BITS-1:0]  rsp_marked_pnl,
   output logic [adxe_pkg::PCT_BITS-1:0]          rsp_adx_value,
   input  logic                                   csr_write_enable,
   input  logic [adxe_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [adxe_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   localparam int PB = adxe_pkg::PRICE_BITS;
   localparam int FB = adxe_pkg::FRAC_BITS;
   localparam int AB = adxe_pkg::ATR_BITS;
   localparam int DB = adxe_pkg::DI_BITS;
   localparam int TB = adxe_pkg::PCT_BITS;
   localparam int CB = adxe_pkg::CASH_BITS;
   localparam int QB = adxe_pkg::QUO_BITS;
   localparam int HB = DB + 7;          // width of diff * 100
   localparam int DXS = QB - FB;        // dividend bits that go into the shift-in part ahead of the fraction zeros

   adxe_pkg::state_type  state_ff, state_in;
   adxe_pkg::sm_sel_type sm_sel_ff;

   logic [TB-1:0]                       thr_ff;
   logic [adxe_pkg::ALPHA_BITS-1:0]     alpha_ff;
   logic [adxe_pkg::LIMIT_BITS-1:0]     limit_ff;
   logic [adxe_pkg::ALPHA_BITS-1:0]     alpha_eff;

   logic                  have_prev_ff, seeded_ff;
   logic [PB-1:0]         hi_ff, lo_ff, pc_ff, cl_ff;
   logic [PB-1:0]         prev_high_ff, prev_low_ff;
   logic [PB-1:0]         dmp_ff, dmm_ff;
   logic [AB-1:0]         atr_ff;
   logic [DB-1:0]         dip_avg_ff, dim_avg_ff, dip_raw_ff, dim_raw_ff;
   logic [TB-1:0]         adx_avg_ff;
   logic signed [adxe_pkg::POS_BITS-1:0] held_ff;
   logic signed [CB-1:0]  cash_ff;
   logic [AB-1:0]         sm_old_ff, sm_x_ff;
   logic [AB:0]           prod_hi_ff;
   logic signed [adxe_pkg::PROD_BITS-1:0] pnl_prod_ff;

   logic                  rsp_valid_ff;
   logic [adxe_pkg::ACT_BITS-1:0] act_ff;
   logic signed [CB-1:0]  pnl_ff;
   logic [TB-1:0]         rsp_adx_ff;

   logic                  req_take, rsp_take, out_blocked;

   // shared multiplier
   logic signed [adxe_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [adxe_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [adxe_pkg::PROD_BITS-1:0]  mul_p;

   // smoothing step
   logic          sm_up;
   logic [AB-1:0] sm_d;
   logic [32:0]   lo_round;
   logic [AB:0]   sm_step;
   logic [AB-1:0] sm_res;

   // bar terms
   logic signed [PB+1:0] t_hl, t_hp, t_pl, tr_max, tr_c;
   logic [AB-1:0]        trq;

   // divider setup
   logic [PB-1:0]  dm_cur;
   logic           di_zero, di_sat;
   logic [DB-1:0]  dx_diff;
   logic [DB:0]    dx_sum;
   logic [HB-1:0]  dx_hund;
   logic           dx_zero;
   logic [TB-1:0]  dx_val;
   logic           dx_ready;

   adxe_pkg::div_req_type  div_req;
   adxe_pkg::div_stat_type div_stat;
   logic [QB-1:0]          div_q;

   // trade
   logic signed [adxe_pkg::POS_BITS-1:0] lim_s;
   logic          buy, sell;
   logic signed [CB:0] cash_wide;
   logic signed [CB:0] pnl_wide;

   function automatic logic signed [CB-1:0] sat48(input logic signed [CB:0] v);
      logic signed [CB-1:0] r;
      if (v[CB] != v[CB-1])
         r = v[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      else
         r = v[CB-1:0];
      return r;
   endfunction

   adxe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign out_blocked = rsp_valid_ff && rsp_stall;

   assign alpha_eff = (alpha_ff > adxe_pkg::ALPHA_ONE) ? adxe_pkg::ALPHA_ONE : alpha_ff;

   // true range of the bar, clamped at zero
   always_comb begin
      t_hl   = $signed({2'b00, hi_ff}) - $signed({2'b00, lo_ff});
      t_hp   = $signed({2'b00, hi_ff}) - $signed({2'b00, pc_ff});
      t_pl   = $signed({2'b00, pc_ff}) - $signed({2'b00, lo_ff});
      tr_max = t_hl;
      if (t_hp > tr_max)
         tr_max = t_hp;
      if (t_pl > tr_max)
         tr_max = t_pl;
      tr_c = tr_max[PB+1] ? '0 : tr_max;
      trq  = {tr_c[PB-1:0], {FB{1'b0}}};
   end

   always_comb begin
      sm_up    = sm_x_ff >= sm_old_ff;
      sm_d     = sm_up ? (sm_x_ff - sm_old_ff) : (sm_old_ff - sm_x_ff);
      lo_round = {1'b0, mul_p[31:0]} + 33'h0_0000_8000;
      sm_step  = prod_hi_ff + {{(AB+1-17){1'b0}}, lo_round[32:16]};
      sm_res   = sm_up ? (sm_old_ff + sm_step[AB-1:0]) : (sm_old_ff - sm_step[AB-1:0]);
   end

   always_comb begin
      dm_cur  = (state_ff == adxe_pkg::S_DIVM_INIT) ? dmm_ff : dmp_ff;
      di_zero = atr_ff == '0;
      di_sat  = {1'b0, dm_cur, {(FB-1){1'b0}}} >= atr_ff;
      dx_diff = (dip_avg_ff >= dim_avg_ff) ? (dip_avg_ff - dim_avg_ff)
                                           : (dim_avg_ff - dip_avg_ff);
      dx_sum  = {1'b0, dip_avg_ff} + {1'b0, dim_avg_ff};
      dx_hund = HB'(dx_diff) * HB'(100);
      dx_zero = dx_sum == '0;
      dx_ready = ((state_ff == adxe_pkg::S_DX_INIT) && dx_zero) ||
                 ((state_ff == adxe_pkg::S_DX_RUN) && div_stat.done);
      dx_val  = (state_ff == adxe_pkg::S_DX_RUN) ? div_q : '0;
   end

   always_comb begin
      lim_s     = $signed({1'b0, limit_ff});
      buy       = (adx_avg_ff > thr_ff) && (held_ff < lim_s);
      sell      = !buy && (adx_avg_ff < thr_ff) && (held_ff > -lim_s);
      cash_wide = {cash_ff[CB-1], cash_ff};
      pnl_wide  = {cash_ff[CB-1], cash_ff} +
                  {{(CB+1-adxe_pkg::PROD_BITS){pnl_prod_ff[adxe_pkg::PROD_BITS-1]}}, pnl_prod_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         adxe_pkg::S_IDLE:
            if (req_take && have_prev_ff)
               state_in = adxe_pkg::S_PREP;
         adxe_pkg::S_PREP:
            state_in = seeded_ff ? adxe_pkg::S_SM_HI : adxe_pkg::S_DIVP_INIT;
         adxe_pkg::S_SM_HI:
            state_in = adxe_pkg::S_SM_LO;
         adxe_pkg::S_SM_LO: begin
            unique case (sm_sel_ff)
               adxe_pkg::SM_ATR: state_in = adxe_pkg::S_DIVP_INIT;
               adxe_pkg::SM_DIP: state_in = adxe_pkg::S_SM_HI;
               adxe_pkg::SM_DIM: state_in = adxe_pkg::S_DX_INIT;
               adxe_pkg::SM_ADX: state_in = adxe_pkg::S_TRADE;
               default:          state_in = adxe_pkg::S_IDLE;
            endcase
         end
         adxe_pkg::S_DIVP_INIT:
            state_in = (di_zero || di_sat) ? adxe_pkg::S_DIVM_INIT : adxe_pkg::S_DIVP_RUN;
         adxe_pkg::S_DIVP_RUN:
            if (div_stat.done)
               state_in = adxe_pkg::S_DIVM_INIT;
         adxe_pkg::S_DIVM_INIT:
            if (di_zero || di_sat)
               state_in = seeded_ff ? adxe_pkg::S_SM_HI : adxe_pkg::S_DX_INIT;
            else
               state_in = adxe_pkg::S_DIVM_RUN;
         adxe_pkg::S_DIVM_RUN:
            if (div_stat.done)
               state_in = seeded_ff ? adxe_pkg::S_SM_HI : adxe_pkg::S_DX_INIT;
         adxe_pkg::S_DX_INIT:
            if (dx_zero)
               state_in = seeded_ff ? adxe_pkg::S_SM_HI : adxe_pkg::S_TRADE;
            else
               state_in = adxe_pkg::S_DX_RUN;
         adxe_pkg::S_DX_RUN:
            if (div_stat.done)
               state_in = seeded_ff ? adxe_pkg::S_SM_HI : adxe_pkg::S_TRADE;
         adxe_pkg::S_TRADE:
            state_in = adxe_pkg::S_PNL;
         adxe_pkg::S_PNL:
            state_in = adxe_pkg::S_PNL_SUM;
         adxe_pkg::S_PNL_SUM:
            if (!out_blocked)
               state_in = adxe_pkg::S_IDLE;
         default:
            state_in = adxe_pkg::S_IDLE;
      endcase
   end

   // control outputs: handshake, multiplier operands, divider launch
   always_comb begin
      req_stall          = 1'b1;
      mul_a              = '0;
      mul_b              = '0;
      div_req.start      = 1'b0;
      div_req.steps      = adxe_pkg::DI_STEPS;
      div_req.rem_init   = {1'b0, dm_cur, {(FB-1){1'b0}}};
      div_req.shift_init = '0;
      div_req.divisor    = atr_ff;
      unique case (state_ff)
         adxe_pkg::S_IDLE:
            req_stall = 1'b0;
         adxe_pkg::S_SM_HI: begin
            mul_a = $signed({1'b0, sm_d[AB-1:FB]});
            mul_b = $signed({1'b0, alpha_eff});
         end
         adxe_pkg::S_SM_LO: begin
            mul_a = $signed({{(adxe_pkg::MUL_A_BITS-FB){1'b0}}, sm_d[FB-1:0]});
            mul_b = $signed({1'b0, alpha_eff});
         end
         adxe_pkg::S_DIVP_INIT, adxe_pkg::S_DIVM_INIT:
            div_req.start = !(di_zero || di_sat);
         adxe_pkg::S_DX_INIT: begin
            div_req.start      = !dx_zero;
            div_req.steps      = adxe_pkg::DX_STEPS;
            div_req.rem_init   = {{(AB-(HB-DXS)){1'b0}}, dx_hund[HB-1:DXS]};
            div_req.shift_init = {dx_hund[DXS-1:0], {FB{1'b0}}};
            div_req.divisor    = {{(AB-DB-1){1'b0}}, dx_sum};
         end
         adxe_pkg::S_PNL: begin
            mul_a = $signed({1'b0, cl_ff});
            mul_b = $signed({{(adxe_pkg::MUL_B_BITS-adxe_pkg::POS_BITS){held_ff[15]}},
                             held_ff});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= adxe_pkg::THRESHOLD_RESET;
         alpha_ff <= adxe_pkg::ALPHA_RESET;
         limit_ff <= adxe_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            adxe_pkg::CSR_ADX_THRESHOLD:   thr_ff   <= csr_write_data;
            adxe_pkg::CSR_SMOOTHING_ALPHA: alpha_ff <= csr_write_data[adxe_pkg::ALPHA_BITS-1:0];
            adxe_pkg::CSR_POSITION_LIMIT:  limit_ff <= csr_write_data[adxe_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= adxe_pkg::S_IDLE;
      else
         state_ff <= state_in;
   end

   // a new result and a transfer of the held one may fall on the same edge
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (state_ff == adxe_pkg::S_PNL_SUM && !out_blocked)
         rsp_valid_ff <= 1'b1;
      else if (rsp_take)
         rsp_valid_ff <= 1'b0;
   end

   // series state and trade bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         seeded_ff    <= 1'b0;
         prev_high_ff <= '0;
         prev_low_ff  <= '0;
         atr_ff       <= '0;
         dip_avg_ff   <= '0;
         dim_avg_ff   <= '0;
         adx_avg_ff   <= '0;
         held_ff      <= '0;
         cash_ff      <= '0;
      end else begin
         case (state_ff)
            adxe_pkg::S_IDLE:
               if (req_take) begin
                  hi_ff <= req_bar_high;
                  lo_ff <= req_bar_low;
                  pc_ff <= req_prior_close;
                  cl_ff <= req_bar_close;
                  if (!have_prev_ff) begin
                     have_prev_ff <= 1'b1;
                     prev_high_ff <= req_bar_high;
                     prev_low_ff  <= req_bar_low;
                  end
               end
            adxe_pkg::S_PREP: begin
               dmp_ff       <= (hi_ff > prev_high_ff) ? (hi_ff - prev_high_ff) : '0;
               dmm_ff       <= (prev_low_ff > lo_ff) ? (prev_low_ff - lo_ff) : '0;
               prev_high_ff <= hi_ff;
               prev_low_ff  <= lo_ff;
               if (seeded_ff) begin
                  sm_old_ff <= atr_ff;
                  sm_x_ff   <= trq;
                  sm_sel_ff <= adxe_pkg::SM_ATR;
               end else begin
                  atr_ff <= trq;
               end
            end
            adxe_pkg::S_SM_HI:
               prod_hi_ff <= mul_p[AB:0];
            adxe_pkg::S_SM_LO: begin
               case (sm_sel_ff)
                  adxe_pkg::SM_ATR: atr_ff <= sm_res;
                  adxe_pkg::SM_DIP: begin
                     dip_avg_ff <= sm_res[DB-1:0];
                     sm_old_ff  <= {{(AB-DB){1'b0}}, dim_avg_ff};
                     sm_x_ff    <= {{(AB-DB){1'b0}}, dim_raw_ff};
                     sm_sel_ff  <= adxe_pkg::SM_DIM;
                  end
                  adxe_pkg::SM_DIM: dim_avg_ff <= sm_res[DB-1:0];
                  default: begin
                     adx_avg_ff <= sm_res[TB-1:0];
                     seeded_ff  <= 1'b1;
                  end
               endcase
            end
            adxe_pkg::S_DIVP_INIT:
               if (di_zero)
                  dip_raw_ff <= '0;
               else if (di_sat)
                  dip_raw_ff <= '1;
            adxe_pkg::S_DIVP_RUN:
               if (div_stat.done)
                  dip_raw_ff <= div_q[DB-1:0];
            adxe_pkg::S_DIVM_INIT, adxe_pkg::S_DIVM_RUN: begin
               // the minus ratio is ready here either way once this step ends
               if ((state_ff == adxe_pkg::S_DIVM_INIT && (di_zero || di_sat)) ||
                   (state_ff == adxe_pkg::S_DIVM_RUN && div_stat.done)) begin
                  if (seeded_ff) begin
                     sm_old_ff <= {{(AB-DB){1'b0}}, dip_avg_ff};
                     sm_x_ff   <= {{(AB-DB){1'b0}}, dip_raw_ff};
                     sm_sel_ff <= adxe_pkg::SM_DIP;
                  end else begin
                     dip_avg_ff <= dip_raw_ff;
                  end
               end
               if (state_ff == adxe_pkg::S_DIVM_INIT) begin
                  if (di_zero) begin
                     dim_raw_ff <= '0;
                     if (!seeded_ff)
                        dim_avg_ff <= '0;
                  end else if (di_sat) begin
                     dim_raw_ff <= '1;
                     if (!seeded_ff)
                        dim_avg_ff <= '1;
                  end
               end else if (div_stat.done) begin
                  dim_raw_ff <= div_q[DB-1:0];
                  if (!seeded_ff)
                     dim_avg_ff <= div_q[DB-1:0];
               end
            end
            adxe_pkg::S_DX_INIT, adxe_pkg::S_DX_RUN:
               if (dx_ready) begin
                  if (seeded_ff) begin
                     sm_old_ff <= {{(AB-TB){1'b0}}, adx_avg_ff};
                     sm_x_ff   <= {{(AB-TB){1'b0}}, dx_val};
                     sm_sel_ff <= adxe_pkg::SM_ADX;
                  end else begin
                     adx_avg_ff <= dx_val;
                     seeded_ff  <= 1'b1;
                  end
               end
            adxe_pkg::S_TRADE: begin
               if (buy) begin
                  act_ff  <= adxe_pkg::ACT_BUY;
                  cash_ff <= sat48(cash_wide - $signed({{(CB+1-PB){1'b0}}, cl_ff}));
                  held_ff <= held_ff + 16'sd1;
               end else if (sell) begin
                  act_ff  <= adxe_pkg::ACT_SELL;
                  cash_ff <= sat48(cash_wide + $signed({{(CB+1-PB){1'b0}}, cl_ff}));
                  held_ff <= held_ff - 16'sd1;
               end else begin
                  act_ff  <= adxe_pkg::ACT_HOLD;
               end
            end
            adxe_pkg::S_PNL:
               pnl_prod_ff <= mul_p;
            adxe_pkg::S_PNL_SUM:
               if (!out_blocked) begin
                  pnl_ff       <= sat48(pnl_wide);
                  rsp_adx_ff   <= adx_avg_ff;
               end
            default: ;
         endcase
      end
   end

   // action and position freeze into the output register with the pnl
   logic [adxe_pkg::ACT_BITS-1:0]        out_act_ff;
   logic signed [adxe_pkg::POS_BITS-1:0] out_pos_ff;
   logic signed [CB-1:0]                 out_cash_ff;

   always_ff @(posedge clock) begin
      if (state_ff == adxe_pkg::S_PNL_SUM && !out_blocked) begin
         out_act_ff  <= act_ff;
         out_pos_ff  <= held_ff;
         out_cash_ff <= cash_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = out_act_ff;
   assign rsp_position   = out_pos_ff;
   assign rsp_cashflow   = out_cash_ff;
   assign rsp_marked_pnl = pnl_ff;
   assign rsp_adx_value  = rsp_adx_ff;

endmodule

### rtl/adxe_divider.sv
module adxe_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  adxe_pkg::div_req_type             req,
   output adxe_pkg::div_stat_type            stat,
   output logic [adxe_pkg::QUO_BITS-1:0]     quotient
);

   logic [adxe_pkg::ATR_BITS-1:0] rem_ff, rem_in;
   logic [adxe_pkg::ATR_BITS-1:0] div_ff;
   logic [adxe_pkg::QUO_BITS-1:0] shift_ff;
   logic [adxe_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic [adxe_pkg::CNT_BITS-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [adxe_pkg::ATR_BITS:0]   trial;
   logic [adxe_pkg::ATR_BITS:0]   less;
   logic                          fits;

   // one restoring step: bring down the next dividend bit
   always_comb begin
      trial  = {rem_ff, shift_ff[adxe_pkg::QUO_BITS-1]};
      less   = trial - {1'b0, div_ff};
      fits   = trial >= {1'b0, div_ff};
      rem_in = fits ? less[adxe_pkg::ATR_BITS-1:0] : trial[adxe_pkg::ATR_BITS-1:0];
      quo_in = {quo_ff[adxe_pkg::QUO_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == adxe_pkg::CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff   <= req.rem_init;
         div_ff   <= req.divisor;
         shift_ff <= req.shift_init;
         quo_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= {shift_ff[adxe_pkg::QUO_BITS-2:0], 1'b0};
         quo_ff   <= quo_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### rtl/adxe_checker.sv
`include "adx_trend_position_engine_unit_assert.svh"

module adxe_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [23:0]         req_bar_high,
   input logic [23:0]         req_bar_low,
   input logic [23:0]         req_prior_close,
   input logic [23:0]         req_bar_close,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_action,
   input logic signed [15:0]  rsp_position,
   input logic signed [47:0]  rsp_cashflow,
   input logic signed [47:0]  rsp_marked_pnl,
   input logic [22:0]         rsp_adx_value,
   input logic                csr_write_enable,
   input logic [1:0]          csr_index,
   input logic [22:0]         csr_write_data
);

   logic unused_in;
   logic [136:0] rsp_payload;

   assign unused_in = req_valid ^ (^req_bar_high) ^ (^req_bar_low) ^ (^req_prior_close) ^
                      (^req_bar_close) ^ csr_write_enable ^ (^csr_index) ^
                      (^csr_write_data);

   assign rsp_payload = {rsp_action, rsp_position, rsp_cashflow, rsp_marked_pnl,
                         rsp_adx_value};

   // results come only out of a busy sequencer
   `ADXE_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

   // reset empties the output register
   `ADXE_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // no unused action code reaches the port
   `ADXE_ASSERT_NOW(a_action_code, clock, reset, rsp_valid, rsp_action != 2'd3)

   // a held result keeps its payload
   `ADXE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind adx_trend_position_engine_unit adxe_checker u_adxe_checker (.*);
